FILE: src/bsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants, request and status codes, and a byte popcount helper for the bitmap
// slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int BITMAP_BYTES_DEF = 1024;
  localparam int WORD_BITS        = 64;
  localparam int WORD_BYTES       = 8;

  localparam int IPG_W   = 14;
  localparam int GRP_W   = 16;
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 13;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 13;
  localparam int GLOB_W  = 29;
  localparam int FREE_W  = 14;
  localparam int CFG_W   = 16;

  localparam logic [IPG_W-1:0] IPG_RESET = 14'd8192;

  localparam logic [0:0] CFG_IPG = 1'b0;
  localparam logic [0:0] CFG_GRP = 1'b1;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_ALR_FREE = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, v[i]};
    end
    return c;
  endfunction

endpackage

FILE: src/bitmap_slot_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// First-fit slot allocator over a one-bit-per-slot occupancy bitmap held in
// a 64-bit-wide synchronous memory.
// Allocate: one memory word (64 slots) checked per cycle, from word 0 up,
// until a free slot is found or the slots below the limit are used up.
// Free and load: one read-modify-write, the word read at start, written in
// the RMW state, with the strobe registered from there. Rejected requests:
// strobe in the cycle after start. One request at a time; busy drops with
// the strobe. The receiver cannot stall. After reset a clearing pass over
// every memory word holds busy high.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top #(
  parameter int BITMAP_BYTES = bsa_pkg::BITMAP_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [bsa_pkg::REQ_W-1:0]   in_req_type,
  input  logic [bsa_pkg::IDX_W-1:0]   in_item_index,
  input  logic [bsa_pkg::BYTE_W-1:0]  in_byte_value,
  output logic                        out_valid,
  output logic [bsa_pkg::STAT_W-1:0]  out_status,
  output logic [bsa_pkg::SLOT_W-1:0]  out_local_slot,
  output logic [bsa_pkg::GLOB_W-1:0]  out_global_slot,
  output logic [bsa_pkg::FREE_W-1:0]  out_free_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [bsa_pkg::CFG_W-1:0]   cfg_data
);

  localparam int WORDS = (BITMAP_BYTES + bsa_pkg::WORD_BYTES - 1) / bsa_pkg::WORD_BYTES;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CAP   = 8 * BITMAP_BYTES;
  localparam int UW    = $clog2(CAP + 1);
  localparam int CW    = (UW > bsa_pkg::IPG_W) ? UW : bsa_pkg::IPG_W;
  localparam int WB    = bsa_pkg::WORD_BITS;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RMW
  } state_t;

  state_t                      state_r, state_nxt;
  logic [AW-1:0]               clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]               chk_word_r, chk_word_nxt;
  logic [bsa_pkg::IPG_W-1:0]   rem_r, rem_nxt;
  logic [UW-1:0]               used_r, used_nxt;
  logic                        op_load_r, op_load_nxt;
  logic [5:0]                  bitpos_r, bitpos_nxt;
  logic [7:0]                  val_r, val_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [bsa_pkg::STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [bsa_pkg::SLOT_W-1:0]  out_local_r, out_local_nxt;
  logic [bsa_pkg::GLOB_W-1:0]  out_global_r, out_global_nxt;
  logic [bsa_pkg::FREE_W-1:0]  out_free_r, out_free_nxt;

  logic [bsa_pkg::IPG_W-1:0]   ipg_r;
  logic [bsa_pkg::GRP_W-1:0]   grp_r;
  logic [bsa_pkg::GLOB_W-1:0]  base_r;

  logic [WB-1:0]               mem [WORDS];
  logic [WB-1:0]               rd_data_r;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [WB-1:0]               mem_wd;

  logic [bsa_pkg::IPG_W-1:0]   limit;
  logic [WB-1:0]               lim_mask;
  logic [WB-1:0]               cand;
  logic [7:0]                  byte_hit;
  logic [2:0]                  fbyte;
  logic [2:0]                  fbit;
  logic [7:0]                  hit_byte;
  logic [AW+5:0]               slot_full;
  logic [bsa_pkg::SLOT_W-1:0]  found_slot;
  logic [12:0]                 free_word;
  logic [12:0]                 load_word;
  logic [7:0]                  old_byte;
  logic [UW-1:0]               used_alloc;
  logic [UW-1:0]               used_load;

  function automatic logic [bsa_pkg::FREE_W-1:0] free_of(
    input logic [UW-1:0]             u,
    input logic [bsa_pkg::IPG_W-1:0] ipg
  );
    logic [CW:0] ue;
    logic [CW:0] ie;
    ue = (CW+1)'(u);
    ie = (CW+1)'(ipg);
    return (ue >= ie) ? '0 : bsa_pkg::FREE_W'(ie - ue);
  endfunction

  assign busy            = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_local_slot  = out_local_r;
  assign out_global_slot = out_global_r;
  assign out_free_count  = out_free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipg_r <= bsa_pkg::IPG_RESET;
      grp_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bsa_pkg::CFG_IPG: ipg_r <= cfg_data[bsa_pkg::IPG_W-1:0];
        bsa_pkg::CFG_GRP: grp_r <= cfg_data[bsa_pkg::GRP_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    base_r <= bsa_pkg::GLOB_W'({{bsa_pkg::GRP_W{1'b0}}, ipg_r} *
                               {{bsa_pkg::IPG_W{1'b0}}, grp_r});
  end

  always_comb begin
    if ({{(CW - bsa_pkg::IPG_W + 1){1'b0}}, ipg_r} < (CW+1)'(CAP)) begin
      limit = ipg_r;
    end else begin
      limit = bsa_pkg::IPG_W'(CAP);
    end
  end

  // per-bit scan order: byte ascending, bit 0..7 within byte -> bit index ascending
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      lim_mask[b] = (|rem_r[bsa_pkg::IPG_W-1:6]) || ((6'(b) ^ 6'd7) < rem_r[5:0]);
    end
    cand = ~rd_data_r & lim_mask;
    for (int k = 0; k < 8; k++) begin
      byte_hit[k] = |cand[8*k +: 8];
    end
    fbyte = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (byte_hit[k]) begin
        fbyte = 3'(k);
      end
    end
    hit_byte = cand[8*fbyte +: 8];
    fbit = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (hit_byte[j]) begin
        fbit = 3'(j);
      end
    end
  end

  assign slot_full  = {chk_word_r, fbyte, ~fbit};
  assign found_slot = bsa_pkg::SLOT_W'(slot_full);
  assign free_word  = {6'd0, in_item_index[12:6]};
  assign load_word  = {3'd0, in_item_index[12:3]};
  assign old_byte   = rd_data_r[8*bitpos_r[5:3] +: 8];
  assign used_alloc = used_r + UW'(1);
  assign used_load  = used_r - UW'(bsa_pkg::pop8(old_byte)) + UW'(bsa_pkg::pop8(val_r));

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    chk_word_nxt   = chk_word_r;
    rem_nxt        = rem_r;
    used_nxt       = used_r;
    op_load_nxt    = op_load_r;
    bitpos_nxt     = bitpos_r;
    val_nxt        = val_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_local_nxt  = out_local_r;
    out_global_nxt = out_global_r;
    out_free_nxt   = out_free_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    mem_we         = 1'b0;
    mem_wa         = chk_word_r;
    mem_wd         = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        if (clr_addr_r == AW'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          out_local_nxt  = '0;
          out_global_nxt = '0;
          out_free_nxt   = free_of(used_r, ipg_r);
          out_status_nxt = bsa_pkg::ST_RANGE;
          priority if (in_req_type == bsa_pkg::REQ_ALLOC) begin
            if (limit == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = bsa_pkg::ST_FULL;
            end else begin
              rd_en        = 1'b1;
              rd_addr      = '0;
              chk_word_nxt = '0;
              rem_nxt      = limit;
              state_nxt    = S_SCAN;
            end
          end else if (in_req_type == bsa_pkg::REQ_FREE &&
                       {1'b0, in_item_index} < limit) begin
            rd_en       = 1'b1;
            rd_addr     = free_word[AW-1:0];
            chk_word_nxt = free_word[AW-1:0];
            bitpos_nxt  = {in_item_index[5:3], ~in_item_index[2:0]};
            op_load_nxt = 1'b0;
            state_nxt   = S_RMW;
          end else if (in_req_type == bsa_pkg::REQ_LOAD &&
                       {1'b0, in_item_index} < bsa_pkg::IPG_W'(BITMAP_BYTES)) begin
            rd_en        = 1'b1;
            rd_addr      = load_word[AW-1:0];
            chk_word_nxt = load_word[AW-1:0];
            bitpos_nxt   = {in_item_index[2:0], 3'd0};
            val_nxt      = in_byte_value;
            op_load_nxt  = 1'b1;
            state_nxt    = S_RMW;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end

      S_SCAN: begin
        if (|cand) begin
          mem_we         = 1'b1;
          mem_wd         = rd_data_r | (WB'(1) << {fbyte, fbit});
          used_nxt       = used_alloc;
          out_valid_nxt  = 1'b1;
          out_status_nxt = bsa_pkg::ST_OK;
          out_local_nxt  = found_slot;
          out_global_nxt = base_r + bsa_pkg::GLOB_W'(found_slot);
          out_free_nxt   = free_of(used_alloc, ipg_r);
          state_nxt      = S_IDLE;
        end else if (rem_r <= bsa_pkg::IPG_W'(WB)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bsa_pkg::ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          rem_nxt      = rem_r - bsa_pkg::IPG_W'(WB);
          chk_word_nxt = chk_word_r + AW'(1);
          rd_en        = 1'b1;
          rd_addr      = chk_word_r + AW'(1);
        end
      end

      S_RMW: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (op_load_r) begin
          mem_we         = 1'b1;
          mem_wd         = rd_data_r;
          mem_wd[8*bitpos_r[5:3] +: 8] = val_r;
          used_nxt       = used_load;
          out_status_nxt = bsa_pkg::ST_OK;
          out_free_nxt   = free_of(used_load, ipg_r);
        end else if (rd_data_r[bitpos_r]) begin
          mem_we         = 1'b1;
          mem_wd         = rd_data_r & ~(WB'(1) << bitpos_r);
          used_nxt       = used_r - UW'(1);
          out_status_nxt = bsa_pkg::ST_OK;
          out_free_nxt   = free_of(used_r - UW'(1), ipg_r);
        end else begin
          out_status_nxt = bsa_pkg::ST_ALR_FREE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    chk_word_r   <= chk_word_nxt;
    rem_r        <= rem_nxt;
    op_load_r    <= op_load_nxt;
    bitpos_r     <= bitpos_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_local_r  <= out_local_nxt;
    out_global_r <= out_global_nxt;
    out_free_r   <= out_free_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

FILE: tb/tb_bitmap_slot_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_slot_allocator_top
// Self-checking bench for the first-fit bitmap slot allocator. A clocked
// driver issues allocate, free, load and unused-code requests from a queue
// and predicts every reply from its own copy of the bitmap, the used count
// and the group registers. A clocked monitor compares each strobed reply
// with the oldest prediction. Register settings change between phases, from
// the smallest group to the full bitmap, with random gaps between requests except in back-to-back phases.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator_top;

  localparam int                        STORE_BYTES = bsa_pkg::BITMAP_BYTES_DEF;
  localparam logic [bsa_pkg::REQ_W-1:0] REQ_NOP     = 2'd3;
  localparam int                        STALL_LIMIT = 4000;
  localparam int                        DRAIN_WAIT  = 300;

  typedef struct packed {
    logic [bsa_pkg::REQ_W-1:0]  req_type;
    logic [bsa_pkg::IDX_W-1:0]  item_index;
    logic [bsa_pkg::BYTE_W-1:0] byte_value;
  } slot_request_t;

  typedef struct packed {
    logic [bsa_pkg::STAT_W-1:0] status;
    logic [bsa_pkg::SLOT_W-1:0] local_slot;
    logic [bsa_pkg::GLOB_W-1:0] global_slot;
    logic [bsa_pkg::FREE_W-1:0] free_count;
  } slot_reply_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [bsa_pkg::REQ_W-1:0]   in_req_type = '0;
  logic [bsa_pkg::IDX_W-1:0]   in_item_index = '0;
  logic [bsa_pkg::BYTE_W-1:0]  in_byte_value = '0;
  logic                        out_valid;
  logic [bsa_pkg::STAT_W-1:0]  out_status;
  logic [bsa_pkg::SLOT_W-1:0]  out_local_slot;
  logic [bsa_pkg::GLOB_W-1:0]  out_global_slot;
  logic [bsa_pkg::FREE_W-1:0]  out_free_count;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [0:0]                  cfg_index = '0;
  logic [bsa_pkg::CFG_W-1:0]   cfg_data = '0;

  slot_request_t request_q[$];
  slot_reply_t   reply_q[$];

  logic [7:0]  occupancy [STORE_BYTES];
  int unsigned used_slots;
  int unsigned group_size;
  int unsigned group_id;

  bit          no_gap = 1'b0;
  int unsigned gap_left = 0;
  int          error_count = 0;
  int          request_count = 0;
  int          setting_count = 0;
  int          status_tally [4] = '{0, 0, 0, 0};
  int          stall_cycles = 0;

  bitmap_slot_allocator_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_item_index   (in_item_index),
    .in_byte_value   (in_byte_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_local_slot  (out_local_slot),
    .out_global_slot (out_global_slot),
    .out_free_count  (out_free_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic slot_reply_t apply_request(input slot_request_t rq);
    slot_reply_t rsp;
    int unsigned limit;
    int unsigned slot;
    int unsigned b;
    int unsigned bit_pos;
    logic [31:0] glob;
    bit          found;
    limit = (group_size < STORE_BYTES * 8) ? group_size : STORE_BYTES * 8;
    rsp = '0;
    rsp.status = bsa_pkg::ST_RANGE;
    case (rq.req_type)
      bsa_pkg::REQ_ALLOC: begin
        rsp.status = bsa_pkg::ST_FULL;
        found = 1'b0;
        for (int i = 0; i < STORE_BYTES && !found && i * 8 < limit; i++) begin
          for (int j = 0; j < 8 && !found; j++) begin
            slot = i * 8 + 7 - j;
            if (slot < limit && !occupancy[i][j]) begin
              occupancy[i][j] = 1'b1;
              used_slots++;
              glob = group_size * group_id + slot;
              rsp.local_slot = slot[bsa_pkg::SLOT_W-1:0];
              rsp.global_slot = glob[bsa_pkg::GLOB_W-1:0];
              rsp.status = bsa_pkg::ST_OK;
              found = 1'b1;
            end
          end
        end
      end
      bsa_pkg::REQ_FREE: begin
        if (rq.item_index < limit) begin
          b = rq.item_index >> 3;
          bit_pos = 7 - (rq.item_index & 7);
          if (!occupancy[b][bit_pos]) begin
            rsp.status = bsa_pkg::ST_ALR_FREE;
          end else begin
            occupancy[b][bit_pos] = 1'b0;
            used_slots--;
            rsp.status = bsa_pkg::ST_OK;
          end
        end
      end
      bsa_pkg::REQ_LOAD: begin
        if (rq.item_index < STORE_BYTES) begin
          used_slots = used_slots - $countones(occupancy[rq.item_index])
                       + $countones(rq.byte_value);
          occupancy[rq.item_index] = rq.byte_value;
          rsp.status = bsa_pkg::ST_OK;
        end
      end
      default: begin
        rsp.status = bsa_pkg::ST_RANGE;
      end
    endcase
    rsp.free_count = (used_slots >= group_size) ? '0 :
                     bsa_pkg::FREE_W'(group_size - used_slots);
    return rsp;
  endfunction

  // driver: present queued requests, predict each transfer
  always @(posedge clk) begin : drive_proc
    int unsigned   gap;
    slot_request_t nxt;
    slot_reply_t   pred;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      pred = apply_request({in_req_type, in_item_index, in_byte_value});
      reply_q = {reply_q, pred};
      request_count++;
      gap = no_gap ? 0 : $urandom_range(0, 7);
      if (gap == 0 && request_q.size() > 0) begin
        nxt = request_q.pop_front();
        in_req_type <= nxt.req_type;
        in_item_index <= nxt.item_index;
        in_byte_value <= nxt.byte_value;
      end else begin
        start <= 1'b0;
        gap_left <= gap;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (request_q.size() > 0) begin
        nxt = request_q.pop_front();
        in_req_type <= nxt.req_type;
        in_item_index <= nxt.item_index;
        in_byte_value <= nxt.byte_value;
        start <= 1'b1;
      end
    end
  end

  // monitor: compare each strobed reply with the oldest prediction
  always @(posedge clk) begin : check_proc
    slot_reply_t exp;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        $error("reply with none pending: status %0d slot %0d", out_status, out_local_slot);
        error_count++;
      end else begin
        exp = reply_q.pop_front();
        status_tally[exp.status]++;
        if (out_status !== exp.status) begin
          $error("status: expected %0d, actual %0d", exp.status, out_status);
          error_count++;
        end
        if (out_local_slot !== exp.local_slot) begin
          $error("local_slot: expected %0d, actual %0d", exp.local_slot, out_local_slot);
          error_count++;
        end
        if (out_global_slot !== exp.global_slot) begin
          $error("global_slot: expected %0d, actual %0d", exp.global_slot, out_global_slot);
          error_count++;
        end
        if (out_free_count !== exp.free_count) begin
          $error("free_count: expected %0d, actual %0d", exp.free_count, out_free_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_request(input logic [bsa_pkg::REQ_W-1:0] rt, input int unsigned idx,
                             input int unsigned val);
    slot_request_t rq;
    rq.req_type = rt;
    rq.item_index = idx[bsa_pkg::IDX_W-1:0];
    rq.byte_value = val[bsa_pkg::BYTE_W-1:0];
    request_q = {request_q, rq};
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (request_q.size() != 0 || start || busy || reply_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[bsa_pkg::CFG_W-1:0];
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == bsa_pkg::CFG_IPG) begin
      group_size = val & 32'h3FFF;
    end else begin
      group_id = val & 32'hFFFF;
    end
  endtask

  task automatic set_group(input int unsigned ipg, input int unsigned grp);
    write_reg(bsa_pkg::CFG_IPG, ipg);
    write_reg(bsa_pkg::CFG_GRP, grp);
    setting_count++;
  endtask

  task automatic queue_fill(input int unsigned nbytes);
    for (int b = 0; b < nbytes; b++) begin
      add_request(bsa_pkg::REQ_LOAD, b, 8'hFF);
    end
    for (int k = 0; k < 4; k++) begin
      add_request(bsa_pkg::REQ_ALLOC, $urandom_range(0, 8191), $urandom_range(0, 255));
    end
  endtask

  task automatic queue_random_mix(input int n, input int unsigned lim);
    int unsigned sel;
    int unsigned idx;
    int unsigned val;
    int unsigned nb;
    nb = (lim + 7) / 8;
    if (nb > STORE_BYTES - 1) begin
      nb = STORE_BYTES - 1;
    end
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      idx = $urandom_range(0, 8191);
      val = $urandom_range(0, 255);
      if (sel < 45) begin
        add_request(bsa_pkg::REQ_ALLOC, idx, val);
      end else if (sel < 75) begin
        if ($urandom_range(0, 6) != 0) begin
          idx = $urandom_range(0, lim - 1);
        end
        add_request(bsa_pkg::REQ_FREE, idx, val);
      end else if (sel < 95) begin
        if ($urandom_range(0, 4) != 0) begin
          idx = $urandom_range(0, nb + 1);
        end
        case ($urandom_range(0, 9))
          0, 1, 2: val = 8'hFF;
          3:       val = 8'h00;
          default: ;
        endcase
        add_request(bsa_pkg::REQ_LOAD, idx, val);
      end else begin
        add_request(REQ_NOP, idx, val);
      end
    end
  endtask

  initial begin : stim_proc
    int unsigned ipg;
    int unsigned grp;
    for (int i = 0; i < STORE_BYTES; i++) begin
      occupancy[i] = 8'h00;
    end
    used_slots = 0;
    group_size = 8192;
    group_id = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: full-size group, group zero
    @(negedge clk);
    add_request(bsa_pkg::REQ_ALLOC, 0, 0);
    add_request(bsa_pkg::REQ_ALLOC, 8191, 255);
    add_request(bsa_pkg::REQ_ALLOC, 0, 0);
    add_request(bsa_pkg::REQ_FREE, 6, 0);
    add_request(bsa_pkg::REQ_FREE, 6, 0);
    add_request(bsa_pkg::REQ_FREE, 8191, 0);
    add_request(bsa_pkg::REQ_LOAD, 0, 8'hFF);
    add_request(bsa_pkg::REQ_ALLOC, 0, 0);
    add_request(bsa_pkg::REQ_LOAD, 1023, 8'h00);
    add_request(bsa_pkg::REQ_LOAD, 1024, 8'hFF);
    add_request(bsa_pkg::REQ_LOAD, 8191, 8'hA5);
    add_request(REQ_NOP, 8191, 8'hFF);
    add_request(bsa_pkg::REQ_FREE, 0, 0);
    wait_idle();

    // smallest group, largest group number: fill, full, saturate
    set_group(8, 65535);
    @(negedge clk);
    for (int k = 0; k < 9; k++) begin
      add_request(bsa_pkg::REQ_ALLOC, 0, 0);
    end
    add_request(bsa_pkg::REQ_FREE, 8, 0);
    add_request(bsa_pkg::REQ_FREE, 7, 0);
    add_request(bsa_pkg::REQ_LOAD, 1, 8'hFF);
    add_request(bsa_pkg::REQ_ALLOC, 0, 0);
    add_request(bsa_pkg::REQ_ALLOC, 0, 0);
    wait_idle();

    // largest group and number: top slot of the bitmap
    set_group(8192, 65535);
    @(negedge clk);
    add_request(bsa_pkg::REQ_LOAD, 1023, 8'hFE);
    add_request(bsa_pkg::REQ_FREE, 8191, 0);
    add_request(bsa_pkg::REQ_ALLOC, 0, 0);
    wait_idle();

    for (int p = 0; p < 14; p++) begin
      case (p % 4)
        0:       ipg = $urandom_range(8, 64);
        1:       ipg = $urandom_range(65, 600);
        2:       ipg = (p % 8 == 2) ? 8192 : 8;
        default: ipg = $urandom_range(8, 8192);
      endcase
      case (p % 5)
        0:       grp = 0;
        1:       grp = 65535;
        default: grp = $urandom_range(0, 65535);
      endcase
      set_group(ipg, grp);
      @(negedge clk);
      no_gap = (p % 3 == 2);
      if (ipg <= 600 && $urandom_range(0, 2) == 0) begin
        queue_fill((ipg + 7) / 8);
      end
      queue_random_mix(95, ipg);
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d requests under %0d register settings after reset defaults.",
             request_count, setting_count);
    $display("Replies ok %0d, full %0d, already free %0d, out of range %0d.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (error_count == 0 && reply_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
